[src/pip_pkg.sv]
// Shared types and constants for the point-in-polygon-with-holes block.
package pip_pkg;

  // Width of the coordinate fields on the item channel
  localparam int unsigned IN_COORD_W = 16;

  // A hole with fewer vertices than this is skipped by queries
  localparam int unsigned MIN_HOLE_VERTICES = 3;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_HOLE   = 2'd2,
    OP_QUERY  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TBL,
    S_WALK,
    S_DRAIN,
    S_RESULT
  } state_e;

  // Vertex beat from the store into the edge unit
  typedef struct packed {
    logic valid;
    logic first;
  } edge_req_t;

  // Edge unit status back to the sequencer
  typedef struct packed {
    logic busy;
    logic flip;
  } edge_sts_t;

endpackage

[src/pip_in_if.sv]
// Item channel: opcode, coordinates and hole-check flag with valid/ready.
interface pip_in_if import pip_pkg::*;;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   opcode;
  logic signed [IN_COORD_W-1:0] coord_x;
  logic signed [IN_COORD_W-1:0] coord_y;
  logic                         check_holes;

  modport source (output valid, opcode, coord_x, coord_y, check_holes, input ready);
  modport sink   (input valid, opcode, coord_x, coord_y, check_holes, output ready);
endinterface

[src/pip_out_if.sv]
// Result channel: query flags with valid/ready.
interface pip_out_if;
  logic valid;
  logic ready;
  logic inside_res;
  logic in_hole;
  logic overflowed;

  modport source (output valid, inside_res, in_hole, overflowed, input ready);
  modport sink   (input valid, inside_res, in_hole, overflowed, output ready);
endinterface

[src/pip_edge.sv]
// Edge crossing unit: forms edges from consecutive vertex beats and flags crossings.
module pip_edge import pip_pkg::*; #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  edge_req_t                    req_i,
  input  logic signed [COORD_BITS-1:0] x_i,
  input  logic signed [COORD_BITS-1:0] y_i,
  input  logic signed [COORD_BITS-1:0] px_i,
  input  logic signed [COORD_BITS-1:0] py_i,
  output edge_sts_t                    sts_o
);

  localparam int unsigned DW = COORD_BITS + 1;
  localparam int unsigned PW = 2 * DW;

  logic signed [COORD_BITS-1:0] prev_x_q, prev_y_q;

  logic                 s1v_q, cross1_q;
  logic signed [DW-1:0] dxp_q, dyv_q, dxv_q, dpy_q;
  logic                 s1v_d, cross1_d;
  logic signed [DW-1:0] dxp_d, dyv_d, dxv_d, dpy_d;

  logic                 s2v_q, cross2_q, neg_q;
  logic signed [PW-1:0] lhs_q, rhs_q;
  logic signed [PW-1:0] lhs_d, rhs_d;

  logic cond;

  // Stage 1: crossing test and differences for the edge (current, previous)
  always_comb begin
    s1v_d    = req_i.valid && !req_i.first;
    cross1_d = (y_i >= py_i) != (prev_y_q >= py_i);
    dxp_d    = DW'(px_i) - DW'(x_i);
    dyv_d    = DW'(prev_y_q) - DW'(y_i);
    dxv_d    = DW'(prev_x_q) - DW'(x_i);
    dpy_d    = DW'(py_i) - DW'(y_i);
  end

  // Stage 2: cross-multiply instead of dividing by dy
  always_comb begin
    lhs_d = PW'(dxp_q) * PW'(dyv_q);
    rhs_d = PW'(dxv_q) * PW'(dpy_q);
  end

  // Stage 3: compare, direction set by the sign of dy
  always_comb begin
    cond  = neg_q ? (lhs_q >= rhs_q) : (lhs_q <= rhs_q);
    sts_o = '{busy: s1v_q || s2v_q, flip: s2v_q && cross2_q && cond};
  end

  // Hold the previous vertex of the walk
  always_ff @(posedge clk_i) begin
    if (req_i.valid) begin
      prev_x_q <= x_i;
      prev_y_q <= y_i;
    end
  end

  // Advance stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1v_q <= 1'b0;
      s2v_q <= 1'b0;
    end else begin
      s1v_q <= s1v_d;
      s2v_q <= s1v_q;
    end
  end

  // Stage payload
  always_ff @(posedge clk_i) begin
    cross1_q <= cross1_d;
    dxp_q    <= dxp_d;
    dyv_q    <= dyv_d;
    dxv_q    <= dxv_d;
    dpy_q    <= dpy_d;
    cross2_q <= cross1_q;
    neg_q    <= dyv_q[DW-1];
    lhs_q    <= lhs_d;
    rhs_q    <= rhs_d;
  end

endmodule

[src/point_in_polygon_with_holes_top.sv]
// Point-in-polygon with holes: contour store, vertex memory and query sequencer.
// Clear, append and begin-hole items take effect at the beat they are accepted in.
// A query walks each contour from the vertex memory, one vertex read a cycle;
// empty contours and holes under MIN_HOLE_VERTICES vertices are skipped.
// Reset empties the store to the outline alone; vertex memory contents are not cleared.
module point_in_polygon_with_holes_top import pip_pkg::*; #(
  parameter int unsigned MAX_VERTICES = 256,
  parameter int unsigned MAX_CONTOURS = 8,
  parameter int unsigned COORD_BITS   = 16
) (
  input logic     clk_i,
  input logic     rst_ni,
  pip_in_if.sink  in_i,
  pip_out_if.source out_o
);

  localparam int unsigned VA  = $clog2(MAX_VERTICES);
  localparam int unsigned VTW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned CI  = (MAX_CONTOURS > 1) ? $clog2(MAX_CONTOURS) : 1;
  localparam int unsigned CNW = $clog2(MAX_CONTOURS + 1);
  localparam int unsigned CB  = COORD_BITS;

  // Vertex memory
  logic [CB-1:0] mem_x [MAX_VERTICES];
  logic [CB-1:0] mem_y [MAX_VERTICES];

  // Contour table
  logic [VTW-1:0] len_q   [MAX_CONTOURS];
  logic [VTW-1:0] start_q [MAX_CONTOURS];

  // Store bookkeeping
  logic [CNW-1:0] cnt_q, cnt_d;
  logic [VTW-1:0] vtot_q, vtot_d;
  logic [VTW-1:0] cur_len_q, cur_len_d;
  logic           ovf_q, ovf_d;
  logic [CI-1:0]  cur;

  // Table and memory write controls
  logic           tw_en, tw_st_en, vw_en;
  logic [CI-1:0]  tw_addr;
  logic [VTW-1:0] tw_len, tw_start;

  // Query sequencer
  state_e                state_q, state_d;
  logic signed [CB-1:0]  in_x, in_y;
  logic signed [CB-1:0]  px_q, py_q;
  logic                  chk_q;
  logic [CI-1:0]         qc_q;
  logic [VTW-1:0]        cs_q, cl_q, k_q;
  logic [VTW-1:0]        tbl_len;
  logic                  odd_q, outl_q, hole_q;
  logic                  skip, last, drained;
  logic                  rd_en, rv_q, rfirst_q;
  logic [VTW-1:0]        raddr_w;
  logic [VA-1:0]         raddr;
  logic signed [CB-1:0]  rdx_q, rdy_q;
  edge_req_t             edge_req;
  edge_sts_t             edge_sts;

  // Result register
  logic out_valid_q, out_load;
  logic inside_q, in_hole_q, ovf_out_q;

  logic in_fire;
  op_e  op;

  assign in_fire     = in_i.valid && in_i.ready;
  assign in_i.ready  = (state_q == S_IDLE);
  assign op          = op_e'(in_i.opcode);
  assign cur         = CI'(cnt_q - CNW'(1));

  // Sign-extend the incoming coordinates to COORD_BITS, or wrap them when narrower
  if (CB >= IN_COORD_W) begin : g_coord_wide
    assign in_x = CB'(in_i.coord_x);
    assign in_y = CB'(in_i.coord_y);
  end else begin : g_coord_narrow
    assign in_x = in_i.coord_x[CB-1:0];
    assign in_y = in_i.coord_y[CB-1:0];
  end

  // Decode store commands
  always_comb begin
    cnt_d     = cnt_q;
    vtot_d    = vtot_q;
    cur_len_d = cur_len_q;
    ovf_d     = ovf_q;
    tw_en     = 1'b0;
    tw_st_en  = 1'b0;
    tw_addr   = cur;
    tw_len    = '0;
    tw_start  = vtot_q;
    vw_en     = 1'b0;
    if (in_fire) begin
      unique case (op)
        OP_CLEAR: begin
          cnt_d     = CNW'(1);
          vtot_d    = '0;
          cur_len_d = '0;
          ovf_d     = 1'b0;
          tw_en     = 1'b1;
          tw_addr   = '0;
        end
        OP_APPEND: begin
          if (!ovf_q) begin
            if (vtot_q == VTW'(MAX_VERTICES)) begin
              ovf_d = 1'b1;
            end else begin
              vw_en     = 1'b1;
              vtot_d    = vtot_q + VTW'(1);
              cur_len_d = cur_len_q + VTW'(1);
              tw_en     = 1'b1;
              tw_len    = cur_len_q + VTW'(1);
            end
          end
        end
        OP_HOLE: begin
          if (!ovf_q) begin
            if (cnt_q > CNW'(1) && cur_len_q < VTW'(MIN_HOLE_VERTICES)) begin
              // Restart the short hole in the same slot
              vtot_d    = vtot_q - cur_len_q;
              cur_len_d = '0;
              tw_en     = 1'b1;
              tw_st_en  = 1'b1;
              tw_start  = vtot_q - cur_len_q;
            end else if (cnt_q == CNW'(MAX_CONTOURS)) begin
              ovf_d = 1'b1;
            end else begin
              cnt_d     = cnt_q + CNW'(1);
              cur_len_d = '0;
              tw_en     = 1'b1;
              tw_st_en  = 1'b1;
              tw_addr   = CI'(cnt_q);
            end
          end
        end
        OP_QUERY: begin
        end
      endcase
    end
  end

  // Contour table lookups for the contour under query
  always_comb begin
    tbl_len = len_q[qc_q];
    skip    = (tbl_len == '0) ||
              (qc_q != '0 && tbl_len < VTW'(MIN_HOLE_VERTICES));
    last    = (CNW'(qc_q) + CNW'(1)) == cnt_q;
    drained = !rv_q && !edge_sts.busy;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_fire && op == OP_QUERY) state_d = S_TBL;
      S_TBL: begin
        if (!skip)     state_d = S_WALK;
        else if (last) state_d = S_RESULT;
      end
      S_WALK:   if (k_q == cl_q) state_d = S_DRAIN;
      S_DRAIN:  if (drained) state_d = last ? S_RESULT : S_TBL;
      S_RESULT: if (out_load) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Sequencer outputs: vertex reads and result load
  always_comb begin
    rd_en    = (state_q == S_WALK);
    raddr_w  = (k_q == '0) ? (cs_q + cl_q - VTW'(1)) : (cs_q + k_q - VTW'(1));
    raddr    = raddr_w[VA-1:0];
    out_load = (state_q == S_RESULT) && (!out_valid_q || out_o.ready);
  end

  // Store bookkeeping and sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= CNW'(1);
      vtot_q    <= '0;
      cur_len_q <= '0;
      ovf_q     <= 1'b0;
      qc_q      <= '0;
      k_q       <= '0;
      odd_q     <= 1'b0;
      outl_q    <= 1'b0;
      hole_q    <= 1'b0;
      rv_q      <= 1'b0;
      rfirst_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      vtot_q    <= vtot_d;
      cur_len_q <= cur_len_d;
      ovf_q     <= ovf_d;
      rv_q      <= rd_en;
      rfirst_q  <= (k_q == '0);
      if (edge_sts.flip) odd_q <= !odd_q;
      unique case (state_q)
        S_IDLE: begin
          qc_q   <= '0;
          outl_q <= 1'b0;
          hole_q <= 1'b0;
        end
        S_TBL: begin
          k_q   <= '0;
          odd_q <= 1'b0;
          if (skip) qc_q <= CI'(qc_q + CI'(1));
        end
        S_WALK: k_q <= k_q + VTW'(1);
        S_DRAIN: begin
          if (drained) begin
            if (qc_q == '0) outl_q <= odd_q;
            else            hole_q <= hole_q || odd_q;
            qc_q <= CI'(qc_q + CI'(1));
          end
        end
        S_RESULT: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Latch query point; fetch the contour entry
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      px_q  <= in_x;
      py_q  <= in_y;
      chk_q <= in_i.check_holes;
    end
    if (state_q == S_TBL) begin
      cs_q <= (qc_q == '0) ? '0 : start_q[qc_q];
      cl_q <= tbl_len;
    end
  end

  // Contour lengths: reset to zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(MAX_CONTOURS); i++) len_q[i] <= '0;
    end else if (tw_en) begin
      len_q[tw_addr] <= tw_len;
    end
  end

  // Contour starts: written when a hole opens
  always_ff @(posedge clk_i) begin
    if (tw_st_en) start_q[tw_addr] <= tw_start;
  end

  // Vertex memory: write on append, registered read while walking
  always_ff @(posedge clk_i) begin
    if (vw_en) begin
      mem_x[vtot_q[VA-1:0]] <= in_x;
      mem_y[vtot_q[VA-1:0]] <= in_y;
    end
    if (rd_en) begin
      rdx_q <= mem_x[raddr];
      rdy_q <= mem_y[raddr];
    end
  end

  // Vertex beat into the edge unit
  assign edge_req.valid = rv_q;
  assign edge_req.first = rfirst_q;

  pip_edge #(
    .COORD_BITS (COORD_BITS)
  ) u_edge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (edge_req),
    .x_i    (rdx_q),
    .y_i    (rdy_q),
    .px_i   (px_q),
    .py_i   (py_q),
    .sts_o  (edge_sts)
  );

  // Result beat: hold until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      inside_q  <= outl_q && !(chk_q && hole_q);
      in_hole_q <= outl_q && hole_q;
      ovf_out_q <= ovf_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.inside_res = inside_q;
  assign out_o.in_hole    = in_hole_q;
  assign out_o.overflowed = ovf_out_q;

  // Contour count stays between the outline alone and capacity
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != '0 && cnt_q <= CNW'(MAX_CONTOURS))
    else $error("contour count out of range");

  // Open contour never holds more vertices than the store
  a_vtot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vtot_q <= VTW'(MAX_VERTICES) && cur_len_q <= vtot_q)
    else $error("vertex total or open contour length out of range");

  // Edge pipeline is empty whenever a new beat can be taken
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> (!rv_q && !edge_sts.busy))
    else $error("edge pipeline busy while accepting beats");

  // Store stays frozen while a query walks it
  a_store_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |=> ($stable(vtot_q) && $stable(cnt_q) && $stable(ovf_q)))
    else $error("store changed during a query");

endmodule
